// ----- hdl/vmx_pkg.sv -----
// Shared types and constants for the voice mixer.
package vmx_pkg;

   // Operation codes carried by req_operation
   localparam logic [2:0] OP_LOAD     = 3'd0;
   localparam logic [2:0] OP_START    = 3'd1;
   localparam logic [2:0] OP_PAUSE    = 3'd2;
   localparam logic [2:0] OP_STOP     = 3'd3;
   localparam logic [2:0] OP_STOP_ALL = 3'd4;
   localparam logic [2:0] OP_TICK     = 3'd5;

   // Sample width register codes
   localparam logic [1:0] WIDTH_BYTE = 2'd1;
   localparam logic [1:0] WIDTH_WORD = 2'd2;

   // Fixed point: values carry 16 fraction bits
   localparam int Q_BITS = 16;
   localparam int VAL_W  = 33;
   localparam int SMP_W  = 17;

   // Clamp limits in Q16 (256 and 32768)
   localparam logic [VAL_W-1:0] MQ_NARROW = 33'h001000000;
   localparam logic [VAL_W-1:0] MQ_WIDE   = 33'h080000000;

   // Per-voice record held in the voice memory
   typedef struct packed {
      logic [15:0] start;
      logic [16:0] total;
      logic [15:0] pos;
      logic [16:0] rem;
      logic [7:0]  loops;
   } voice_rec_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WALK, ST_REC, ST_RD0, ST_RD1, ST_MIX, ST_FIN
   } top_state_type;

   typedef enum logic [1:0] {
      T_IDLE, T_STEP, T_LEAF, T_NODE
   } tree_state_type;

   typedef enum logic [1:0] {
      PH_LEFT, PH_RIGHT, PH_JOIN
   } phase_type;

   typedef enum logic [2:0] {
      N_IDLE, N_MUL, N_PREP, N_DIV, N_OUT
   } node_state_type;

endpackage

// ----- hdl/voice_mixer_laurence.sv -----
// Voice mixer top: command decode, voice walk over the record memory, output word.
// Load, start, pause, stop and stop-all pass through the finish state to the result word.
// A tick skips idle voices, ends voices out of loops and reads one byte (8-bit) or two (16-bit)
// per playing voice, then walks the mix tree; each mix node has a serial divider (49-bit quotient).
// One item is in work at a time; a new word is accepted while the result waits.
// Reset clears voice active/paused flags and sets sample width to 2; memories are not cleared.
module voice_mixer_laurence #(
   parameter int VOICES       = 32,
   parameter int SAMPLE_BYTES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [15:0]        req_address,
   input  logic [7:0]         req_data_byte,
   input  logic [16:0]        req_sound_length,
   input  logic signed [7:0]  req_loop_count,
   input  logic [5:0]         req_voice_select,
   input  logic               req_pause_flag,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_voice_handle,
   output logic signed [15:0] rsp_mixed_sample,
   output logic               rsp_clipped,
   input  logic               csr_we,
   input  logic [1:0]         csr_wdata
);
   import vmx_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW = $clog2(VOICES + 1);
   localparam int AW = $clog2(SAMPLE_BYTES);
   localparam int RW = $bits(voice_rec_type);

   top_state_type      state_ff, state_in;
   logic [1:0]         width_ff;
   logic [VOICES-1:0]  active_ff, active_in, paused_ff, paused_in;
   logic [CW-1:0]      idx_ff, idx_in, cnt_ff, cnt_in;
   voice_rec_type      cur_ff, cur_in;
   logic [7:0]         lo_ff, lo_in;
   logic [5:0]         res_handle_ff, res_handle_in;
   logic signed [15:0] res_sample_ff, res_sample_in;
   logic               res_clip_ff, res_clip_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_handle_ff, rsp_handle_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_clip_ff, rsp_clip_in;

   logic               w_ok, w1;
   logic [VW-1:0]      widx, free_idx, sel_idx;
   logic               free_found, sel_ok;

   logic               smem_we;
   logic [AW-1:0]      smem_waddr, smem_raddr;
   logic [7:0]         smem_rdata;
   logic               rec_we;
   logic [VW-1:0]      rec_waddr;
   voice_rec_type      rec_wdata, rec_rd, rec_n;
   logic [RW-1:0]      rec_rdata;
   logic               vals_we;
   logic signed [SMP_W-1:0] vals_wdata, vals_rdata, smp;
   logic [VW-1:0]      vals_raddr;
   logic               put;
   logic               tree_start, tree_done;
   logic signed [VAL_W-1:0] tree_r;
   logic [VAL_W-1:0]   mix_mag;
   logic signed [17:0] mix_s;
   logic [7:0]         loops_n;

   // sample memory, voice record memory, per-tick sample list
   vmx_ram #(.WIDTH(8), .DEPTH(SAMPLE_BYTES)) u_smem (
      .clock (clock), .we (smem_we), .waddr (smem_waddr), .wdata (req_data_byte),
      .raddr (smem_raddr), .rdata (smem_rdata)
   );

   vmx_ram #(.WIDTH(RW), .DEPTH(VOICES)) u_rec (
      .clock (clock), .we (rec_we), .waddr (rec_waddr), .wdata (rec_wdata),
      .raddr (widx), .rdata (rec_rdata)
   );

   vmx_ram #(.WIDTH(SMP_W), .DEPTH(VOICES)) u_vals (
      .clock (clock), .we (vals_we), .waddr (cnt_ff[VW-1:0]), .wdata (vals_wdata),
      .raddr (vals_raddr), .rdata (vals_rdata)
   );

   vmx_tree #(.VOICES(VOICES)) u_tree (
      .clock   (clock),
      .reset   (reset),
      .start   (tree_start),
      .count   (cnt_ff),
      .wide    (!w1),
      .rd_addr (vals_raddr),
      .rd_data (vals_rdata),
      .done    (tree_done),
      .result  (tree_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_WORD;
         active_ff    <= '0;
         paused_ff    <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         paused_ff    <= paused_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            width_ff <= csr_wdata;
         end
      end
      cur_ff        <= cur_in;
      lo_ff         <= lo_in;
      res_handle_ff <= res_handle_in;
      res_sample_ff <= res_sample_in;
      res_clip_ff   <= res_clip_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   // lowest free voice and handle decode
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VW'(i);
         end
      end
      sel_ok  = (req_voice_select != '0) && ({1'b0, req_voice_select} <= 7'(VOICES));
      sel_idx = VW'(req_voice_select - 6'd1);
      w_ok    = (width_ff == WIDTH_BYTE) || (width_ff == WIDTH_WORD);
      w1      = (width_ff == WIDTH_BYTE);
      widx    = idx_ff[VW-1:0];
   end

   // main sequencer
   always_comb begin
      state_in = state_ff;
      active_in = active_ff;
      paused_in = paused_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      lo_in = lo_ff;
      res_handle_in = res_handle_ff;
      res_sample_in = res_sample_ff;
      res_clip_in = res_clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in = rsp_clip_ff;
      req_ready = 1'b0;
      smem_we = 1'b0;
      smem_waddr = AW'(req_address);
      smem_raddr = AW'(cur_ff.pos);
      rec_we = 1'b0;
      rec_waddr = widx;
      rec_wdata = cur_ff;
      vals_we = 1'b0;
      tree_start = 1'b0;
      put = 1'b0;
      smp = '0;
      rec_rd = voice_rec_type'(rec_rdata);
      rec_n = rec_rd;
      loops_n = rec_rd.loops;
      mix_mag = '0;
      mix_s = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_handle_in = '0;
               res_sample_in = '0;
               res_clip_in = 1'b0;
               state_in = ST_FIN;
               case (req_operation)
                  OP_LOAD: smem_we = 1'b1;
                  OP_START: begin
                     if (req_loop_count != '0 && free_found) begin
                        rec_we = 1'b1;
                        rec_waddr = free_idx;
                        rec_wdata = '{start: req_address, total: req_sound_length,
                                      pos: req_address, rem: req_sound_length,
                                      loops: req_loop_count};
                        active_in[free_idx] = 1'b1;
                        paused_in[free_idx] = 1'b0;
                        res_handle_in = 6'(free_idx + 1'b1);
                     end
                  end
                  OP_PAUSE: begin
                     if (sel_ok && active_ff[sel_idx]) begin
                        paused_in[sel_idx] = req_pause_flag;
                     end
                  end
                  OP_STOP: begin
                     if (sel_ok) begin
                        active_in[sel_idx] = 1'b0;
                     end
                  end
                  OP_STOP_ALL: active_in = '0;
                  OP_TICK: begin
                     if (w_ok) begin
                        idx_in = '0;
                        cnt_in = '0;
                        state_in = ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (idx_ff == CW'(VOICES)) begin
               tree_start = 1'b1;
               state_in = ST_MIX;
            end else if (active_ff[widx] && !paused_ff[widx]) begin
               state_in = ST_REC;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_REC: begin
            // exhausted: count down loops, end or restart
            if (rec_rd.rem == '0) begin
               if (loops_n != '0 && !loops_n[7]) begin
                  loops_n = loops_n - 8'd1;
               end
               rec_n.loops = loops_n;
               rec_n.rem = rec_rd.total;
               rec_n.pos = rec_rd.start;
            end
            if (rec_rd.rem == '0 && loops_n == '0) begin
               active_in[widx] = 1'b0;
               idx_in = idx_ff + 1'b1;
               state_in = ST_WALK;
            end else begin
               cur_in = rec_n;
               smem_raddr = AW'(rec_n.pos);
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            lo_in = smem_rdata;
            if (w1) begin
               put = 1'b1;
               smp = $signed({9'b0, smem_rdata});
            end else begin
               smem_raddr = AW'(cur_ff.pos + 16'd1);
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            put = 1'b1;
            smp = SMP_W'($signed({smem_rdata, lo_ff}));
         end
         ST_MIX: begin
            if (tree_done) begin
               // truncate toward zero, then saturate
               mix_mag = tree_r[VAL_W-1] ? VAL_W'(-tree_r) : VAL_W'(tree_r);
               mix_s = tree_r[VAL_W-1] ? -$signed({1'b0, mix_mag[32:16]})
                                       : $signed({1'b0, mix_mag[32:16]});
               res_clip_in = 1'b0;
               res_sample_in = 16'(mix_s);
               if (w1) begin
                  if (mix_s > 18'sd255) begin
                     res_sample_in = 16'sd255;
                     res_clip_in = 1'b1;
                  end else if (mix_s < 18'sd0) begin
                     res_sample_in = 16'sd0;
                     res_clip_in = 1'b1;
                  end
               end else begin
                  if (mix_s > 18'sd32767) begin
                     res_sample_in = 16'sh7fff;
                     res_clip_in = 1'b1;
                  end else if (mix_s < -18'sd32768) begin
                     res_sample_in = 16'sh8000;
                     res_clip_in = 1'b1;
                  end
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_handle_in = res_handle_ff;
               rsp_sample_in = res_sample_ff;
               rsp_clip_in = res_clip_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // store the fetched sample and write the advanced record back
      if (put) begin
         vals_we = 1'b1;
         cnt_in = cnt_ff + 1'b1;
         rec_we = 1'b1;
         rec_wdata = cur_ff;
         rec_wdata.pos = cur_ff.pos + (w1 ? 16'd1 : 16'd2);
         rec_wdata.rem = (cur_ff.rem > (w1 ? 17'd1 : 17'd2))
                         ? cur_ff.rem - (w1 ? 17'd1 : 17'd2) : 17'd0;
         idx_in = idx_ff + 1'b1;
         state_in = ST_WALK;
      end
      vals_wdata = smp;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voice_handle = rsp_handle_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_clipped      = rsp_clip_ff;

   // the sample count never runs ahead of the voice walk
   a_cnt_le_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (cnt_ff <= idx_ff))
      else $error("sample count ahead of voice index");

   // a voice whose record is being read was seen active
   a_rec_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REC) |-> active_ff[widx])
      else $error("record read for inactive voice");

   // the mix tree finishes only while the tick waits on it
   a_tree_done: assert property (@(posedge clock) disable iff (reset)
      tree_done |-> (state_ff == ST_MIX))
      else $error("mix tree done outside mix state");

   // a result word appears only out of the finish state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result word loaded outside finish state");
endmodule

// ----- hdl/vmx_ram.sv -----
// Generic one-write, one-read RAM with registered read data.
module vmx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- hdl/vmx_node.sv -----
// One mixing node: (a+b)/(1+ab/max^2) in Q16 with a serial divider.
module vmx_node (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            wide,
   input  logic signed [vmx_pkg::VAL_W-1:0] a,
   input  logic signed [vmx_pkg::VAL_W-1:0] b,
   output logic                            done,
   output logic signed [vmx_pkg::VAL_W-1:0] r
);
   import vmx_pkg::*;

   localparam int DIVW = 49;
   localparam int BW   = $clog2(DIVW + 1);

   node_state_type           nstate_ff, nstate_in;
   logic signed [VAL_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]              prod_ff, prod_in;
   logic signed [33:0]       num_ff, num_in;
   logic [32:0]              dvs_ff, dvs_in;
   logic [DIVW-1:0]          quo_ff, quo_in;
   logic [32:0]              rem_ff, rem_in;
   logic [BW-1:0]            bit_ff, bit_in;
   logic                     sat_ff, sat_in;

   logic [VAL_W-1:0] amag, bmag, mq, omag;
   logic [31:0]      tmag;
   logic signed [33:0] tval, dval;
   logic [33:0]      nmag, rs;

   always_ff @(posedge clock) begin
      if (reset) begin
         nstate_ff <= N_IDLE;
      end else begin
         nstate_ff <= nstate_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      sat_ff  <= sat_in;
   end

   // sequencing: multiply, form denominator, divide, clamp
   always_comb begin
      nstate_in = nstate_ff;
      a_in = a_ff; b_in = b_ff; prod_in = prod_ff; num_in = num_ff;
      dvs_in = dvs_ff; quo_in = quo_ff; rem_in = rem_ff; bit_in = bit_ff;
      sat_in = sat_ff;
      done = 1'b0;
      r = '0;
      amag = a_ff[VAL_W-1] ? VAL_W'(-a_ff) : VAL_W'(a_ff);
      bmag = b_ff[VAL_W-1] ? VAL_W'(-b_ff) : VAL_W'(b_ff);
      mq   = wide ? MQ_WIDE : MQ_NARROW;
      tmag = wide ? 32'(prod_ff >> 46) : 32'(prod_ff >> 32);
      tval = (a_ff[VAL_W-1] ^ b_ff[VAL_W-1]) ? -$signed({2'b00, tmag})
                                             : $signed({2'b00, tmag});
      dval = 34'sd65536 + tval;
      nmag = num_ff[33] ? 34'(-num_ff) : 34'(num_ff);
      rs   = {rem_ff, quo_ff[DIVW-1]};
      omag = '0;
      case (nstate_ff)
         N_IDLE: begin
            if (start) begin
               a_in = a;
               b_in = b;
               nstate_in = N_MUL;
            end
         end
         N_MUL: begin
            prod_in = 64'(amag[31:0]) * 64'(bmag[31:0]);
            num_in  = 34'(a_ff) + 34'(b_ff);
            nstate_in = N_PREP;
         end
         N_PREP: begin
            // non-positive denominator saturates by the sign of a+b
            if (dval[33] || dval == '0) begin
               sat_in = 1'b1;
               nstate_in = N_OUT;
            end else begin
               sat_in = 1'b0;
               dvs_in = dval[32:0];
               quo_in = {nmag[32:0], 16'h0000};
               rem_in = '0;
               bit_in = '0;
               nstate_in = N_DIV;
            end
         end
         N_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rs >= {1'b0, dvs_ff}) begin
               rem_in = 33'(rs - {1'b0, dvs_ff});
               quo_in = {quo_ff[DIVW-2:0], 1'b1};
            end else begin
               rem_in = rs[32:0];
               quo_in = {quo_ff[DIVW-2:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BW'(DIVW - 1)) begin
               nstate_in = N_OUT;
            end
         end
         N_OUT: begin
            if (sat_ff) begin
               omag = (num_ff != '0) ? mq : '0;
            end else if (quo_ff > DIVW'(mq)) begin
               omag = mq;
            end else begin
               omag = quo_ff[VAL_W-1:0];
            end
            r = num_ff[33] ? -$signed(omag) : $signed(omag);
            done = 1'b1;
            nstate_in = N_IDLE;
         end
         default: nstate_in = N_IDLE;
      endcase
   end
endmodule

// ----- hdl/vmx_tree.sv -----
// Halving mix tree walked in post-order with a frame stack and one node unit.
module vmx_tree #(
   parameter int VOICES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [$clog2(VOICES+1)-1:0]            count,
   input  logic                                   wide,
   output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] rd_addr,
   input  logic signed [vmx_pkg::SMP_W-1:0]       rd_data,
   output logic                                   done,
   output logic signed [vmx_pkg::VAL_W-1:0]       result
);
   import vmx_pkg::*;

   localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CW  = $clog2(VOICES + 1);
   localparam int SD  = $clog2(VOICES) + 2;
   localparam int SPW = $clog2(SD + 1);

   typedef struct packed {
      logic [VW-1:0]           base;
      logic [CW-1:0]           cnt;
      phase_type               ph;
      logic signed [VAL_W-1:0] left;
   } frame_type;

   tree_state_type          tstate_ff, tstate_in;
   frame_type               stk_ff [SD];
   frame_type               stk_in [SD];
   logic [SPW-1:0]          sp_ff, sp_in;
   logic signed [VAL_W-1:0] ret_ff, ret_in;

   frame_type               top, modtop, child;
   logic [CW-1:0]           half;
   logic                    node_start, node_done;
   logic signed [VAL_W-1:0] node_r;

   vmx_node u_node (
      .clock (clock),
      .reset (reset),
      .start (node_start),
      .wide  (wide),
      .a     (top.left),
      .b     (ret_ff),
      .done  (node_done),
      .r     (node_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tstate_ff <= T_IDLE;
         sp_ff     <= '0;
      end else begin
         tstate_ff <= tstate_in;
         sp_ff     <= sp_in;
      end
      stk_ff <= stk_in;
      ret_ff <= ret_in;
   end

   // frame stack walker
   always_comb begin
      tstate_in  = tstate_ff;
      stk_in     = stk_ff;
      sp_in      = sp_ff;
      ret_in     = ret_ff;
      node_start = 1'b0;
      done       = 1'b0;
      top        = stk_ff[0];
      half       = top.cnt >> 1;
      modtop     = top;
      child      = '{base: top.base, cnt: half, ph: PH_LEFT, left: '0};
      rd_addr    = top.base;
      case (tstate_ff)
         T_IDLE: begin
            if (start) begin
               stk_in[0] = '{base: '0, cnt: count, ph: PH_LEFT, left: '0};
               sp_in = SPW'(1);
               tstate_in = T_STEP;
            end
         end
         T_STEP: begin
            if (sp_ff == '0) begin
               done = 1'b1;
               tstate_in = T_IDLE;
            end else if (top.cnt == '0) begin
               ret_in = '0;
               for (int k = 0; k < SD - 1; k++) stk_in[k] = stk_ff[k+1];
               sp_in = sp_ff - 1'b1;
            end else if (top.cnt == CW'(1)) begin
               tstate_in = T_LEAF;
            end else if (top.ph == PH_JOIN) begin
               node_start = 1'b1;
               tstate_in = T_NODE;
            end else begin
               // descend into left half, then right half
               if (top.ph == PH_LEFT) begin
                  modtop.ph = PH_RIGHT;
               end else begin
                  modtop.ph   = PH_JOIN;
                  modtop.left = ret_ff;
                  child.base  = top.base + VW'(half);
                  child.cnt   = top.cnt - half;
               end
               for (int k = 1; k < SD; k++) stk_in[k] = stk_ff[k-1];
               stk_in[1] = modtop;
               stk_in[0] = child;
               sp_in = sp_ff + 1'b1;
            end
         end
         T_LEAF: begin
            ret_in = VAL_W'(rd_data) <<< Q_BITS;
            for (int k = 0; k < SD - 1; k++) stk_in[k] = stk_ff[k+1];
            sp_in = sp_ff - 1'b1;
            tstate_in = T_STEP;
         end
         T_NODE: begin
            if (node_done) begin
               ret_in = node_r;
               for (int k = 0; k < SD - 1; k++) stk_in[k] = stk_ff[k+1];
               sp_in = sp_ff - 1'b1;
               tstate_in = T_STEP;
            end
         end
         default: tstate_in = T_IDLE;
      endcase
   end

   assign result = ret_ff;
endmodule
